[design/rpc_pkg.sv]
package rpc_pkg;

	// control half of the engine-to-output event transaction
	typedef struct packed {
		logic vld;
		logic is_done;
		logic fin;
	} rpc_ev_t;

	localparam int NUM_STAGES = 4;
	localparam int MAX_RES    = 12;

	// work levels: 0..3 are clip stages, LVL_OUT goes to the output
	localparam logic [2:0] LVL_OUT = 3'd4;

	localparam logic [1:0] REG_LEFT   = 2'd0;
	localparam logic [1:0] REG_BOTTOM = 2'd1;
	localparam logic [1:0] REG_RIGHT  = 2'd2;
	localparam logic [1:0] REG_TOP    = 2'd3;

	localparam logic [1:0] STG_LEFT   = 2'd0;
	localparam logic [1:0] STG_BOTTOM = 2'd1;
	localparam logic [1:0] STG_RIGHT  = 2'd2;
	localparam logic [1:0] STG_TOP    = 2'd3;

endpackage

[design/rpc_div.sv]
module rpc_div #(
	parameter int NUM_W = 26,
	parameter int DEN_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

endmodule

[design/rpc_engine.sv]
module rpc_engine #(
	parameter int COORD_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic signed [COORD_BITS-1:0] win_left,
	input  logic signed [COORD_BITS-1:0] win_bottom,
	input  logic signed [COORD_BITS-1:0] win_right,
	input  logic signed [COORD_BITS-1:0] win_top,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [COORD_BITS-1:0]        in_x,
	input  logic [COORD_BITS-1:0]        in_y,
	input  logic                         in_end,
	output rpc_pkg::rpc_ev_t             ev,
	output logic [COORD_BITS-1:0]        ev_x,
	output logic [COORD_BITS-1:0]        ev_y,
	input  logic                         ev_ready
);
	import rpc_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int AW = CB + 1;
	localparam int PW = 2 * AW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_NEXT = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_EVAL = 3'd3;
	localparam logic [2:0] S_MUL  = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_EMIT = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0] state_q;

	// work item in hand and pending second outputs
	logic          cur_v_q;
	logic [2:0]    cur_lvl_q;
	logic [CB-1:0] cur_x_q;
	logic [CB-1:0] cur_y_q;
	logic [2:0]    stk_lvl_q [NUM_STAGES];
	logic [CB-1:0] stk_x_q [NUM_STAGES];
	logic [CB-1:0] stk_y_q [NUM_STAGES];
	logic [2:0]    sp_q;
	logic [2:0]    sp_m1;

	logic          fin_q;
	logic [2:0]    close_lvl_q;
	logic [1:0]    stg_q;
	logic          closing_q;
	logic [NUM_STAGES-1:0] started_q;
	logic          enter_q;

	// per-stage state word: first x, first y, prev x, prev y
	logic [4*CB-1:0] mem [NUM_STAGES];
	logic [4*CB-1:0] rd_q;
	logic            mem_we;
	logic [4*CB-1:0] wdata;

	logic signed [CB-1:0] fx, fy, px, py, qx, qy, pa, qa, po, qo, cb;
	logic                 ybound, hi_side, ip, iq, first_vtx;
	logic signed [AW-1:0] d_w, dn_w, t_w;
	logic signed [PW-1:0] prod_w;

	logic signed [PW-1:0] prod_s1;
	logic [AW-1:0]        den_s1;
	logic                 neg_s1;
	logic                 div_go_q;
	logic [PW-1:0]        num_mag;
	logic                 div_busy, div_done;
	logic [PW-1:0]        div_quo;
	logic signed [AW-1:0] qs;
	logic [CB-1:0]        oth, cr_x, cr_y;
	logic [2:0]           nxt_lvl;

	assign fx = rd_q[4*CB-1:3*CB];
	assign fy = rd_q[3*CB-1:2*CB];
	assign px = rd_q[2*CB-1:CB];
	assign py = rd_q[CB-1:0];
	assign qx = closing_q ? fx : cur_x_q;
	assign qy = closing_q ? fy : cur_y_q;

	assign ybound  = stg_q[0];
	assign hi_side = stg_q[1];
	assign pa = ybound ? py : px;
	assign qa = ybound ? qy : qx;
	assign po = ybound ? px : py;
	assign qo = ybound ? qx : qy;

	always_comb begin
		unique case (stg_q)
			STG_LEFT:   cb = win_left;
			STG_BOTTOM: cb = win_bottom;
			STG_RIGHT:  cb = win_right;
			STG_TOP:    cb = win_top;
			default:    cb = win_top;
		endcase
	end

	assign ip = hi_side ? (pa <= cb) : (pa >= cb);
	assign iq = hi_side ? (qa <= cb) : (qa >= cb);
	assign first_vtx = !closing_q && !started_q[stg_q];
	assign nxt_lvl = {1'b0, stg_q} + 3'd1;

	assign d_w    = {qa[CB-1], qa} - {pa[CB-1], pa};
	assign dn_w   = {qo[CB-1], qo} - {po[CB-1], po};
	assign t_w    = {cb[CB-1], cb} - {pa[CB-1], pa};
	assign prod_w = dn_w * t_w;

	assign num_mag = prod_s1[PW-1] ? PW'(-prod_s1) : prod_s1;
	assign qs      = neg_s1 ? -$signed(div_quo[AW-1:0]) : $signed(div_quo[AW-1:0]);
	assign oth     = po + qs[CB-1:0];
	assign cr_x    = ybound ? oth : cb;
	assign cr_y    = ybound ? cb : oth;

	assign sp_m1 = sp_q - 3'd1;

	assign mem_we = (state_q == S_EVAL) && !closing_q;
	assign wdata  = first_vtx ? {cur_x_q, cur_y_q, cur_x_q, cur_y_q}
	                          : {fx, fy, cur_x_q, cur_y_q};

	rpc_div #(
		.NUM_W(PW),
		.DEN_W(AW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_go_q),
		.num   (num_mag),
		.den   (den_s1),
		.busy  (div_busy),
		.done  (div_done),
		.quo   (div_quo)
	);

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[stg_q] <= wdata;
		if (state_q == S_RD)
			rd_q <= mem[stg_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			prod_s1 <= prod_w;
			den_s1  <= d_w[AW-1] ? AW'(-d_w) : d_w;
			neg_s1  <= prod_w[PW-1] ^ d_w[AW-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_v_q     <= 1'b0;
			cur_lvl_q   <= '0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			sp_q        <= '0;
			fin_q       <= 1'b0;
			close_lvl_q <= '0;
			stg_q       <= STG_LEFT;
			closing_q   <= 1'b0;
			started_q   <= '0;
			enter_q     <= 1'b0;
			div_go_q    <= 1'b0;
			for (int i = 0; i < NUM_STAGES; i++) begin
				stk_lvl_q[i] <= '0;
				stk_x_q[i]   <= '0;
				stk_y_q[i]   <= '0;
			end
		end else begin
			div_go_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cur_v_q     <= 1'b1;
						cur_lvl_q   <= 3'd0;
						cur_x_q     <= in_x;
						cur_y_q     <= in_y;
						fin_q       <= in_end;
						close_lvl_q <= 3'd0;
						state_q     <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (cur_v_q) begin
						if (cur_lvl_q == LVL_OUT) begin
							state_q <= S_EMIT;
						end else begin
							stg_q     <= cur_lvl_q[1:0];
							closing_q <= 1'b0;
							state_q   <= S_RD;
						end
					end else if (sp_q != 3'd0) begin
						cur_v_q   <= 1'b1;
						cur_lvl_q <= stk_lvl_q[sp_m1[1:0]];
						cur_x_q   <= stk_x_q[sp_m1[1:0]];
						cur_y_q   <= stk_y_q[sp_m1[1:0]];
						sp_q      <= sp_m1;
					end else if (fin_q && !close_lvl_q[2]) begin
						close_lvl_q <= close_lvl_q + 3'd1;
						if (started_q[close_lvl_q[1:0]]) begin
							stg_q     <= close_lvl_q[1:0];
							closing_q <= 1'b1;
							state_q   <= S_RD;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_RD: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					started_q[stg_q] <= !closing_q;
					if (first_vtx) begin
						cur_v_q <= 1'b0;
						state_q <= S_NEXT;
					end else if (ip && iq) begin
						cur_v_q   <= 1'b1;
						cur_lvl_q <= nxt_lvl;
						cur_x_q   <= qx;
						cur_y_q   <= qy;
						state_q   <= S_NEXT;
					end else if (ip || iq) begin
						enter_q <= iq;
						state_q <= S_MUL;
					end else begin
						cur_v_q <= 1'b0;
						state_q <= S_NEXT;
					end
				end
				S_MUL: begin
					div_go_q <= 1'b1;
					state_q  <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						cur_v_q   <= 1'b1;
						cur_lvl_q <= nxt_lvl;
						cur_x_q   <= cr_x;
						cur_y_q   <= cr_y;
						if (enter_q) begin
							stk_lvl_q[sp_q[1:0]] <= nxt_lvl;
							stk_x_q[sp_q[1:0]]   <= qx;
							stk_y_q[sp_q[1:0]]   <= qy;
							sp_q                 <= sp_q + 3'd1;
						end
						state_q <= S_NEXT;
					end
				end
				S_EMIT: begin
					if (ev_ready) begin
						cur_v_q <= 1'b0;
						state_q <= S_NEXT;
					end
				end
				S_DONE: begin
					if (ev_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign ev.vld     = (state_q == S_EMIT) || (state_q == S_DONE);
	assign ev.is_done = (state_q == S_DONE);
	assign ev.fin     = fin_q;
	assign ev_x       = cur_x_q;
	assign ev_y       = cur_y_q;

	// pending outputs strictly rise in level, so at most one per stage
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= 3'd4)
		else $error("work stack overflow");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (sp_q == 3'd0 && !cur_v_q))
		else $error("work left over at end of transaction");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_go_q |-> !div_busy)
		else $error("divider started while busy");

	a_done_all_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && fin_q) |-> (started_q == '0))
		else $error("stage left open after polygon end");

endmodule

[design/rect_polygon_clipper.sv]
// Per input vertex, each stage visit that needs no intersection passes the states NEXT, RD
// and EVAL; each intersection adds the MUL state and a run of the bit-serial divider.
// Throughput: one vertex at a time; the next is taken once every result of the last has
// been handed to the output register. Stage state sits in a 4-entry RAM, one access a cycle.
// Reset (arst_n low): window returns to the full coordinate range, all stages forget
// their vertices; no clearing pass is needed.
module rect_polygon_clipper #(
	parameter int COORD_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_index,
	input  logic [COORD_BITS-1:0]        cfg_data,
	input  logic                         vert_valid,
	output logic                         vert_ready,
	input  logic signed [COORD_BITS-1:0] vert_x,
	input  logic signed [COORD_BITS-1:0] vert_y,
	input  logic                         poly_end,
	output logic                         clip_valid,
	input  logic                         clip_ready,
	output logic signed [COORD_BITS-1:0] clip_x,
	output logic signed [COORD_BITS-1:0] clip_y,
	output logic                         clip_end,
	output logic                         all_clipped
);
	import rpc_pkg::*;

	localparam int CB    = COORD_BITS;
	localparam int KEPT_W = $clog2(MAX_RES + 1);

	logic signed [CB-1:0] win_left_q, win_bottom_q, win_right_q, win_top_q;

	rpc_ev_t       ev;
	logic [CB-1:0] ev_x, ev_y;
	logic          ev_ready, take;

	logic              hold_v_q;
	logic [CB-1:0]     hold_x_q, hold_y_q;
	logic [KEPT_W-1:0] kept_q;
	logic              any_q;
	logic [CB-1:0]     first_x_q, first_y_q;

	logic              out_v_q;
	logic [CB-1:0]     out_x_q, out_y_q;
	logic              out_end_q, out_clip_q;

	logic              load;
	logic [CB-1:0]     ld_x, ld_y;
	logic              ld_end, ld_clip;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left_q   <= {1'b1, {(CB-1){1'b0}}};
			win_bottom_q <= {1'b1, {(CB-1){1'b0}}};
			win_right_q  <= {1'b0, {(CB-1){1'b1}}};
			win_top_q    <= {1'b0, {(CB-1){1'b1}}};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LEFT:   win_left_q   <= cfg_data;
				REG_BOTTOM: win_bottom_q <= cfg_data;
				REG_RIGHT:  win_right_q  <= cfg_data;
				REG_TOP:    win_top_q    <= cfg_data;
				default:    win_top_q    <= win_top_q;
			endcase
		end
	end

	rpc_engine #(
		.COORD_BITS(CB)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.win_left  (win_left_q),
		.win_bottom(win_bottom_q),
		.win_right (win_right_q),
		.win_top   (win_top_q),
		.in_valid  (vert_valid),
		.in_ready  (vert_ready),
		.in_x      (vert_x),
		.in_y      (vert_y),
		.in_end    (poly_end),
		.ev        (ev),
		.ev_x      (ev_x),
		.ev_y      (ev_y),
		.ev_ready  (ev_ready)
	);

	assign ev_ready = !out_v_q || clip_ready;
	assign take     = ev.vld && ev_ready;

	// one vertex is held back so the last one kept can carry the end flag
	always_comb begin
		load    = 1'b0;
		ld_x    = hold_x_q;
		ld_y    = hold_y_q;
		ld_end  = 1'b0;
		ld_clip = 1'b0;
		if (take) begin
			if (!ev.is_done) begin
				load = hold_v_q && (kept_q < KEPT_W'(MAX_RES));
			end else if (hold_v_q) begin
				load   = 1'b1;
				ld_end = ev.fin;
			end else if (ev.fin) begin
				load    = 1'b1;
				ld_end  = 1'b1;
				ld_clip = !any_q;
				ld_x    = any_q ? first_x_q : '0;
				ld_y    = any_q ? first_y_q : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			kept_q   <= '0;
			any_q    <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (load)
				out_v_q <= 1'b1;
			else if (clip_ready)
				out_v_q <= 1'b0;
			if (take) begin
				if (!ev.is_done) begin
					if (kept_q < KEPT_W'(MAX_RES)) begin
						kept_q   <= kept_q + 1'b1;
						hold_v_q <= 1'b1;
						any_q    <= 1'b1;
					end
				end else begin
					hold_v_q <= 1'b0;
					kept_q   <= '0;
					if (ev.fin)
						any_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && !ev.is_done && kept_q < KEPT_W'(MAX_RES)) begin
			hold_x_q <= ev_x;
			hold_y_q <= ev_y;
			if (!any_q) begin
				first_x_q <= ev_x;
				first_y_q <= ev_y;
			end
		end
		if (load) begin
			out_x_q    <= ld_x;
			out_y_q    <= ld_y;
			out_end_q  <= ld_end;
			out_clip_q <= ld_clip;
		end
	end

	assign clip_valid  = out_v_q;
	assign clip_x      = out_x_q;
	assign clip_y      = out_y_q;
	assign clip_end    = out_end_q;
	assign all_clipped = out_clip_q;

	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= KEPT_W'(MAX_RES))
		else $error("kept count past limit");

	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		(clip_valid && all_clipped) |-> (clip_end && clip_x == '0 && clip_y == '0))
		else $error("empty polygon result malformed");

	a_hold_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(take && ev.is_done) |=> (!hold_v_q && kept_q == '0))
		else $error("held vertex survived end of transaction");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
	import rpc_pkg::*;

	localparam int CB = 12;
	localparam int DRAIN_CYCLES = 400;

	typedef struct {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		bit                   e;
		bit                   c;
	} clip_vtx_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_LEFT;
	logic [CB-1:0] cfg_data = '0;
	logic vert_valid = 0;
	logic vert_ready;
	logic signed [CB-1:0] vert_x = '0;
	logic signed [CB-1:0] vert_y = '0;
	logic poly_end = 0;
	logic clip_valid;
	logic clip_ready = 0;
	logic signed [CB-1:0] clip_x;
	logic signed [CB-1:0] clip_y;
	logic clip_end;
	logic all_clipped;

	rect_polygon_clipper #(.COORD_BITS(CB)) uut (.*);

	always #5 clk = ~clk;

	clip_vtx_t pending_clips[$];
	int fails = 0;
	bit calm = 0;

	// window and per-stage clip state as the block should hold it
	longint win[4];
	longint st_fx[4], st_fy[4], st_px[4], st_py[4];
	bit st_on[4];
	bit emitted;
	longint first_ox, first_oy;

	function automatic bit in_window(int s, longint x, longint y);
		case (s)
			STG_LEFT:   return x >= win[REG_LEFT];
			STG_BOTTOM: return y >= win[REG_BOTTOM];
			STG_RIGHT:  return x <= win[REG_RIGHT];
			default:    return y <= win[REG_TOP];
		endcase
	endfunction

	function automatic void clip_edge(int s, longint ax, longint ay, longint bx, longint by,
			ref longint ox[$], ref longint oy[$]);
		bit ia, ib;
		longint c, d, ix, iy;
		ia = in_window(s, ax, ay);
		ib = in_window(s, bx, by);
		if (ia != ib) begin
			if (s == STG_LEFT || s == STG_RIGHT) begin
				c = (s == STG_LEFT) ? win[REG_LEFT] : win[REG_RIGHT];
				d = bx - ax;
				ix = c;
				iy = (d != 0) ? ay + ((by - ay) * (c - ax)) / d : ay;
			end else begin
				c = (s == STG_BOTTOM) ? win[REG_BOTTOM] : win[REG_TOP];
				d = by - ay;
				iy = c;
				ix = (d != 0) ? ax + ((bx - ax) * (c - ay)) / d : ax;
			end
			ox.push_back(ix);
			oy.push_back(iy);
		end
		if (ib) begin
			ox.push_back(bx);
			oy.push_back(by);
		end
	endfunction

	function automatic void predict_clip(longint vx, longint vy, bit fin);
		longint ix[$], iy[$], ox[$], oy[$];
		int k;
		clip_vtx_t r;
		ix.push_back(vx);
		iy.push_back(vy);
		for (int s = 0; s < NUM_STAGES; s++) begin
			ox = {};
			oy = {};
			foreach (ix[i]) begin
				if (!st_on[s]) begin
					st_on[s] = 1;
					st_fx[s] = ix[i];
					st_fy[s] = iy[i];
				end else
					clip_edge(s, st_px[s], st_py[s], ix[i], iy[i], ox, oy);
				st_px[s] = ix[i];
				st_py[s] = iy[i];
			end
			if (fin && st_on[s]) begin
				clip_edge(s, st_px[s], st_py[s], st_fx[s], st_fy[s], ox, oy);
				st_on[s] = 0;
			end
			ix = ox;
			iy = oy;
		end
		k = (ix.size() > MAX_RES) ? MAX_RES : ix.size();
		for (int i = 0; i < k; i++) begin
			if (!emitted) begin
				emitted = 1;
				first_ox = ix[i];
				first_oy = iy[i];
			end
			r.x = CB'(ix[i]);
			r.y = CB'(iy[i]);
			r.e = fin && (i == k - 1);
			r.c = 0;
			pending_clips.push_back(r);
		end
		if (fin) begin
			if (k == 0) begin
				r.x = CB'(emitted ? first_ox : 0);
				r.y = CB'(emitted ? first_oy : 0);
				r.e = 1;
				r.c = !emitted;
				pending_clips.push_back(r);
			end
			emitted = 0;
		end
	endfunction

	function automatic int burst();
		if (calm || $urandom_range(0, 2) != 0)
			return 0;
		return $urandom_range(1, 18);
	endfunction

	// receiver stalls in bursts
	always @(posedge clk) begin
		if (calm)
			clip_ready <= 1;
		else if ($urandom_range(0, 7) == 0)
			clip_ready <= 0;
		else if ($urandom_range(0, 3) == 0)
			clip_ready <= 1;
	end

	always @(posedge clk) begin
		clip_vtx_t w;
		if (arst_n && clip_valid && clip_ready) begin
			if (pending_clips.size() == 0) begin
				$error("unexpected result x=%0d y=%0d", clip_x, clip_y);
				fails++;
			end else begin
				w = pending_clips.pop_front();
				if (clip_end !== w.e) begin
					$error("clip_end expected %0d got %0d", w.e, clip_end);
					fails++;
				end
				if (all_clipped !== w.c) begin
					$error("all_clipped expected %0d got %0d", w.c, all_clipped);
					fails++;
				end
				if (clip_x !== w.x) begin
					$error("clip_x expected %0d got %0d", w.x, clip_x);
					fails++;
				end
				if (clip_y !== w.y) begin
					$error("clip_y expected %0d got %0d", w.y, clip_y);
					fails++;
				end
			end
		end
	end

	task automatic send_vertex(longint x, longint y, bit fin);
		int g;
		g = burst();
		if (g > 0) begin
			vert_valid <= 0;
			repeat (g) @(posedge clk);
		end
		vert_valid <= 1;
		vert_x <= CB'(x);
		vert_y <= CB'(y);
		poly_end <= fin;
		do @(posedge clk); while (!vert_ready);
		predict_clip(vert_x, vert_y, fin);
	endtask

	// a vertex with no results can still be in the engine, so wait for it to go idle
	task automatic wait_drain();
		vert_valid <= 0;
		@(posedge clk);
		while (pending_clips.size() != 0 || !vert_ready) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, longint val);
		wait_drain();
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= CB'(val);
		do @(posedge clk); while (!cfg_ready);
		win[idx] = longint'(signed'(cfg_data));
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic set_window(longint l, longint b, longint r, longint t);
		write_reg(REG_LEFT, l);
		write_reg(REG_BOTTOM, b);
		write_reg(REG_RIGHT, r);
		write_reg(REG_TOP, t);
	endtask

	task automatic send_poly(int n, int span);
		longint cx, cy;
		cx = $signed($urandom_range(0, 1023)) - 512;
		cy = $signed($urandom_range(0, 1023)) - 512;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_vertex($signed(12'($urandom)), $signed(12'($urandom)), i == n - 1);
			else
				send_vertex(cx + $signed($urandom_range(0, 2 * span)) - span,
					cy + $signed($urandom_range(0, 2 * span)) - span, i == n - 1);
		end
	endtask

	task automatic test_reset_window();
		// full window: everything passes, extremes of the coordinate range
		send_vertex(-2048, -2048, 0);
		send_vertex(2047, -2048, 0);
		send_vertex(2047, 2047, 0);
		send_vertex(-2048, 2047, 1);
		send_vertex(5, -7, 1);
	endtask

	task automatic test_small_window();
		set_window(-100, -100, 100, 100);
		// square larger than the window, clipped to its corners
		send_vertex(-500, -500, 0);
		send_vertex(500, -500, 0);
		send_vertex(500, 500, 0);
		send_vertex(-500, 500, 1);
		// wholly outside
		send_vertex(300, 300, 0);
		send_vertex(400, 300, 0);
		send_vertex(350, 400, 1);
		// triangle crossing edges, vertical edge included
		send_vertex(0, 0, 0);
		send_vertex(250, 30, 0);
		send_vertex(0, -300, 1);
		// single vertex outside, then on the boundary
		send_vertex(-101, 0, 1);
		send_vertex(100, -100, 1);
		// zig-zag that yields many results at the close
		send_vertex(-1000, 0, 0);
		send_vertex(0, 1000, 0);
		send_vertex(1000, 0, 0);
		send_vertex(0, -1000, 0);
		send_vertex(-1500, 900, 1);
	endtask

	task automatic test_odd_windows();
		set_window(100, 100, -100, -100);
		send_vertex(0, 0, 0);
		send_vertex(10, 0, 1);
		set_window(0, 0, 0, 0);
		send_vertex(0, 0, 1);
		send_vertex(-5, -5, 0);
		send_vertex(5, 5, 1);
	endtask

	task automatic test_random_windows();
		longint l, b;
		for (int p = 0; p < 6; p++) begin
			l = $signed($urandom_range(0, 1599)) - 800;
			b = $signed($urandom_range(0, 1599)) - 800;
			set_window(l, b, l + $urandom_range(0, 600), b + $urandom_range(0, 600));
			for (int j = 0; j < 10; j++) begin
				send_poly($urandom_range(1, 7), $urandom_range(50, 700));
				if (p == 2 && j == 4)
					wait_drain();
			end
		end
		set_window($signed(12'($urandom)), $signed(12'($urandom)),
			$signed(12'($urandom)), $signed(12'($urandom)));
		for (int j = 0; j < 6; j++)
			send_poly($urandom_range(1, 5), 2047);
	endtask

	task automatic test_full_range();
		set_window(-2048, -2048, 2047, 2047);
		for (int j = 0; j < 8; j++)
			send_poly($urandom_range(1, 5), 2047);
		set_window(-300, -200, 300, 200);
		calm = 1;
		for (int j = 0; j < 14; j++)
			send_poly($urandom_range(2, 6), 600);
	endtask

	initial begin
		win[REG_LEFT] = -2048;
		win[REG_BOTTOM] = -2048;
		win[REG_RIGHT] = 2047;
		win[REG_TOP] = 2047;
		foreach (st_on[s]) begin
			st_on[s] = 0;
			st_fx[s] = 0;
			st_fy[s] = 0;
			st_px[s] = 0;
			st_py[s] = 0;
		end
		emitted = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_reset_window();
		test_small_window();
		test_odd_windows();
		test_random_windows();
		test_full_range();
		wait_drain();
		if (fails == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	initial begin
		#30ms;
		$display("tb: errors");
		$finish;
	end

endmodule
